FILE: src/spu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spu_pkg
// Shared types, codes and constants of the stored PNG RGBA unpacker.
// ----------------------------------------------------------------------------
package spu_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pixel_byte;
    logic [30:0] image_width;
    logic [30:0] image_height;
    logic [3:0]  status;
  } out_item_t;

  // Write strobes into the result queue; second is only set with first.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  localparam logic KindPixel  = 1'b0;
  localparam logic KindStatus = 1'b1;

  localparam logic [3:0] StOk          = 4'd0;
  localparam logic [3:0] StBadSig      = 4'd1;
  localparam logic [3:0] StTruncChunk  = 4'd2;
  localparam logic [3:0] StShortHdr    = 4'd3;
  localparam logic [3:0] StUnsupported = 4'd4;
  localparam logic [3:0] StMissing     = 4'd5;
  localparam logic [3:0] StCompressed  = 4'd6;
  localparam logic [3:0] StOverrun     = 4'd7;
  localparam logic [3:0] StFilter      = 4'd8;
  localparam logic [3:0] StShortData   = 4'd9;

  localparam logic [31:0] TypeIhdr = 32'h4948_4452;
  localparam logic [31:0] TypeIdat = 32'h4944_4154;
  localparam logic [31:0] TypeIend = 32'h4945_4E44;

  localparam logic [7:0] HdrBitDepth      = 8'd8;
  localparam logic [7:0] HdrColorRgba     = 8'd6;
  localparam logic [7:0] HdrInterlaceNone = 8'd0;
  localparam logic [3:0] HdrLen           = 4'd13;
  localparam logic [7:0] FilterNone       = 8'd0;

  localparam int QueueDepth = 4;

  typedef enum logic [4:0] {
    PhSig  = 5'b00001,
    PhChdr = 5'b00010,
    PhBody = 5'b00100,
    PhCrc  = 5'b01000,
    PhEnd  = 5'b10000
  } phase_t;

  typedef enum logic [3:0] {
    StgZlib = 4'b0001,
    StgBhdr = 4'b0010,
    StgData = 4'b0100,
    StgDone = 4'b1000
  } stage_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h89;
      3'd1: b = 8'h50;
      3'd2: b = 8'h4E;
      3'd3: b = 8'h47;
      3'd4: b = 8'h0D;
      3'd5: b = 8'h0A;
      3'd6: b = 8'h1A;
      3'd7: b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: src/stored_png_rgba_unpacker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stored_png_rgba_unpacker_core
// Byte-wide PNG reader for 8-bit RGBA images held in stored deflate blocks.
// ----------------------------------------------------------------------------
// Feed the file one byte per transfer and mark its final byte with last_byte.
// Every byte is parsed in the cycle it is taken and its results are offered
// from the next cycle, so the block accepts one byte per clock while in_stall is low; each byte
// yields at most one pixel byte, and the final byte adds a status result
// (kind 1) carrying the header width and height. Results go through a
// QUEUE_DEPTH-entry queue (default 4): in_stall rises while it holds more
// than QUEUE_DEPTH-2 results, so throughput stays at one byte per cycle as
// long as the consumer takes one result per cycle. Pixel bytes are sent
// before the verdict; drop them when the status is nonzero. After the status
// the parser is back in its reset state, ready for the next file.
module stored_png_rgba_unpacker_core #(
  parameter int QUEUE_DEPTH = spu_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output spu_pkg::out_item_t out_data
);

  spu_pkg::phase_t phase_r, phase_nxt;
  spu_pkg::stage_t stage_r, stage_nxt;
  logic [3:0]  fc_r, fc_nxt;
  logic [31:0] cl_r, cl_nxt;
  logic [31:0] ck_r, ck_nxt;
  logic [31:0] hw_r, hw_nxt;
  logic [31:0] hh_r, hh_nxt;
  logic        seen_r, seen_nxt;
  logic [1:0]  zs_r, zs_nxt;
  logic [15:0] bl_r, bl_nxt;
  logic        bf_r, bf_nxt;
  logic        bb_r, bb_nxt;
  logic [2:0]  bc_r, bc_nxt;
  logic [32:0] rc_r, rc_nxt;
  logic [30:0] ri_r, ri_nxt;
  logic [3:0]  err_r, err_nxt;

  logic        in_acc, walk, last;
  logic [7:0]  b;
  logic        pix_emit;
  logic [31:0] kind_full;
  logic [3:0]  verdict;
  logic        dims_cur_ok, dims_upd_ok;

  spu_pkg::push_t     push;
  spu_pkg::out_item_t pix_item, stat_item;

  assign in_acc = in_valid && !in_stall;
  assign b      = in_data.data_byte;
  assign last   = in_data.last_byte;
  assign walk   = in_acc && (err_r == spu_pkg::StOk);

  assign dims_cur_ok = (hw_r != '0) && !hw_r[31] && (hh_r != '0) && !hh_r[31];
  assign dims_upd_ok = (hw_nxt != '0) && !hw_nxt[31] && (hh_nxt != '0) && !hh_nxt[31];

  always_comb begin
    phase_nxt = phase_r;
    stage_nxt = stage_r;
    fc_nxt    = fc_r;
    cl_nxt    = cl_r;
    ck_nxt    = ck_r;
    hw_nxt    = hw_r;
    hh_nxt    = hh_r;
    seen_nxt  = seen_r;
    zs_nxt    = zs_r;
    bl_nxt    = bl_r;
    bf_nxt    = bf_r;
    bb_nxt    = bb_r;
    bc_nxt    = bc_r;
    rc_nxt    = rc_r;
    ri_nxt    = ri_r;
    err_nxt   = err_r;
    pix_emit  = 1'b0;
    kind_full = {ck_r[23:0], b};

    if (walk) begin
      case (phase_r)
        spu_pkg::PhSig: begin
          if (b != spu_pkg::sig_byte(fc_r[2:0])) begin
            err_nxt = spu_pkg::StBadSig;
          end else if (fc_r == 4'd7) begin
            phase_nxt = spu_pkg::PhChdr;
            fc_nxt    = '0;
          end else begin
            fc_nxt = fc_r + 4'd1;
          end
        end
        spu_pkg::PhChdr: begin
          if (fc_r == 4'd0) begin
            cl_nxt = {24'd0, b};
            ck_nxt = '0;
          end else if (fc_r < 4'd4) begin
            cl_nxt = {cl_r[23:0], b};
          end else begin
            ck_nxt = kind_full;
          end
          if (fc_r == 4'd7) begin
            fc_nxt = '0;
            if (kind_full == spu_pkg::TypeIhdr) begin
              if (cl_r < 32'(spu_pkg::HdrLen)) begin
                err_nxt = spu_pkg::StShortHdr;
              end else if (zs_r != 2'd2) begin
                // header arriving once the stream has begun
                err_nxt = spu_pkg::StMissing;
              end else begin
                seen_nxt = 1'b1;
                hw_nxt   = '0;
                hh_nxt   = '0;
              end
            end
            phase_nxt = (cl_r != '0) ? spu_pkg::PhBody : spu_pkg::PhCrc;
          end else begin
            fc_nxt = fc_r + 4'd1;
          end
        end
        spu_pkg::PhBody: begin
          if (ck_r == spu_pkg::TypeIhdr) begin
            if (fc_r < 4'd4) begin
              hw_nxt = {hw_r[23:0], b};
            end else if (fc_r < 4'd8) begin
              hh_nxt = {hh_r[23:0], b};
            end else if (fc_r == 4'd8 && b != spu_pkg::HdrBitDepth) begin
              err_nxt = spu_pkg::StUnsupported;
            end else if (fc_r == 4'd9 && b != spu_pkg::HdrColorRgba) begin
              err_nxt = spu_pkg::StUnsupported;
            end else if (fc_r == 4'd12 && b != spu_pkg::HdrInterlaceNone) begin
              err_nxt = spu_pkg::StUnsupported;
            end
            if (fc_r < spu_pkg::HdrLen) begin
              fc_nxt = fc_r + 4'd1;
            end
          end else if (ck_r == spu_pkg::TypeIdat) begin
            case (stage_r)
              spu_pkg::StgZlib: begin
                if (zs_r == 2'd2 && !(seen_r && dims_cur_ok)) begin
                  err_nxt = spu_pkg::StMissing;
                end else begin
                  zs_nxt = zs_r - 2'd1;
                  if (zs_r == 2'd1) begin
                    stage_nxt = spu_pkg::StgBhdr;
                    bc_nxt    = '0;
                  end
                end
              end
              spu_pkg::StgBhdr: begin
                if (bc_r == 3'd0) begin
                  bf_nxt = b[0];
                  bb_nxt = (b[2:1] != 2'd0);
                end else if (bc_r == 3'd1) begin
                  bl_nxt = {8'd0, b};
                end else if (bc_r == 3'd2) begin
                  bl_nxt = {b, bl_r[7:0]};
                end
                bc_nxt = bc_r + 3'd1;
                // NLEN bytes are skipped; decide on the fifth header byte
                if (bc_r == 3'd4) begin
                  if (bb_r) begin
                    err_nxt = spu_pkg::StCompressed;
                  end else if (bl_r == '0) begin
                    stage_nxt = bf_r ? spu_pkg::StgDone : spu_pkg::StgBhdr;
                    bc_nxt    = '0;
                  end else begin
                    stage_nxt = spu_pkg::StgData;
                  end
                end
              end
              spu_pkg::StgData: begin
                if ({1'b0, ri_r} < hh_r) begin
                  if (rc_r == '0 && b != spu_pkg::FilterNone) begin
                    err_nxt = spu_pkg::StFilter;
                  end else begin
                    pix_emit = (rc_r != '0);
                    // end of row: column reached 4*width
                    if (rc_r >= {hw_r[30:0], 2'b00}) begin
                      rc_nxt = '0;
                      ri_nxt = ri_r + 31'd1;
                    end else begin
                      rc_nxt = rc_r + 33'd1;
                    end
                  end
                end
                bl_nxt = bl_r - 16'd1;
                if (bl_r == 16'd1) begin
                  stage_nxt = bf_r ? spu_pkg::StgDone : spu_pkg::StgBhdr;
                  bc_nxt    = '0;
                end
              end
              default: begin
              end
            endcase
          end
          cl_nxt = cl_r - 32'd1;
          if (cl_r == 32'd1) begin
            phase_nxt = spu_pkg::PhCrc;
            fc_nxt    = '0;
          end
        end
        spu_pkg::PhCrc: begin
          if (fc_r == 4'd3) begin
            fc_nxt    = '0;
            phase_nxt = (ck_r == spu_pkg::TypeIend) ? spu_pkg::PhEnd : spu_pkg::PhChdr;
          end else begin
            fc_nxt = fc_r + 4'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (err_nxt != spu_pkg::StOk) begin
      verdict = err_nxt;
    end else if (phase_nxt == spu_pkg::PhSig) begin
      verdict = spu_pkg::StBadSig;
    end else if (phase_nxt == spu_pkg::PhBody || phase_nxt == spu_pkg::PhCrc) begin
      verdict = spu_pkg::StTruncChunk;
    end else if (!seen_nxt || !dims_upd_ok || zs_nxt != 2'd0) begin
      verdict = spu_pkg::StMissing;
    end else if (stage_nxt == spu_pkg::StgData && bl_nxt != '0) begin
      verdict = spu_pkg::StOverrun;
    end else if ({1'b0, ri_nxt} < hh_nxt) begin
      verdict = spu_pkg::StShortData;
    end else begin
      verdict = spu_pkg::StOk;
    end
  end

  always_comb begin
    pix_item              = '0;
    pix_item.kind         = spu_pkg::KindPixel;
    pix_item.pixel_byte   = b;
    stat_item             = '0;
    stat_item.kind        = spu_pkg::KindStatus;
    stat_item.image_width  = hw_nxt[30:0];
    stat_item.image_height = hh_nxt[30:0];
    stat_item.status      = verdict;
    push.first  = pix_emit || (in_acc && last);
    push.second = pix_emit && in_acc && last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && last)) begin
      phase_r <= spu_pkg::PhSig;
      stage_r <= spu_pkg::StgZlib;
      fc_r    <= '0;
      cl_r    <= '0;
      ck_r    <= '0;
      hw_r    <= '0;
      hh_r    <= '0;
      seen_r  <= 1'b0;
      zs_r    <= 2'd2;
      bl_r    <= '0;
      bf_r    <= 1'b0;
      bb_r    <= 1'b0;
      bc_r    <= '0;
      rc_r    <= '0;
      ri_r    <= '0;
      err_r   <= spu_pkg::StOk;
    end else begin
      phase_r <= phase_nxt;
      stage_r <= stage_nxt;
      fc_r    <= fc_nxt;
      cl_r    <= cl_nxt;
      ck_r    <= ck_nxt;
      hw_r    <= hw_nxt;
      hh_r    <= hh_nxt;
      seen_r  <= seen_nxt;
      zs_r    <= zs_nxt;
      bl_r    <= bl_nxt;
      bf_r    <= bf_nxt;
      bb_r    <= bb_nxt;
      bc_r    <= bc_nxt;
      rc_r    <= rc_nxt;
      ri_r    <= ri_nxt;
      err_r   <= err_nxt;
    end
  end

  spu_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .wr0         (pix_emit ? pix_item : stat_item),
    .wr1         (stat_item),
    .almost_full (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

FILE: src/spu_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spu_outq
// Result queue: takes up to two results a cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
module spu_outq #(
  parameter int DEPTH = spu_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  spu_pkg::push_t    push,
  input  spu_pkg::out_item_t wr0,
  input  spu_pkg::out_item_t wr1,
  output logic              almost_full,
  output logic              out_valid,
  input  logic              out_stall,
  output spu_pkg::out_item_t out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  spu_pkg::out_item_t mem [DEPTH];

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign out_valid   = (count_r != '0);
  assign out_data    = mem[rd_ptr_r];
  assign pop         = out_valid && !out_stall;
  assign almost_full = (count_r > CW'(DEPTH - 2));
  assign wr_ptr_p1   = ptr_inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push.second) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_p1);
    end else if (push.first) begin
      wr_ptr_nxt = wr_ptr_p1;
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push.first) + CW'(push.second) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_ptr_r] <= wr0;
    end
    if (push.second) begin
      mem[wr_ptr_p1] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: src/spu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spu_checker
// Port-level checks of the unpacker, attached to the top level by bind.
// ----------------------------------------------------------------------------
module spu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input spu_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input spu_pkg::out_item_t out_data
);

  // a pending result stays offered until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled input transfer keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input changed while stalled");

  // reset empties the queue and opens the input
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("queue not empty after reset");

  a_pixel_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == spu_pkg::KindPixel |->
      out_data.status == spu_pkg::StOk && out_data.image_width == '0 &&
      out_data.image_height == '0)
    else $error("pixel result carries status fields");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == spu_pkg::KindStatus |->
      out_data.pixel_byte == 8'd0 && out_data.status <= spu_pkg::StShortData)
    else $error("malformed status result");

endmodule

bind stored_png_rgba_unpacker_core spu_checker u_spu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
